/* design/bcv_pkg.sv */
// ----------------------------------------------------------------------------
// bcv_pkg
// shared types and codes for the bundle container validator
// ----------------------------------------------------------------------------
package bcv_pkg;

  // parse phase of the bundle walk
  typedef enum logic [2:0] {
    PH_HEADER    = 3'd0,
    PH_ENTRY_HDR = 3'd1,
    PH_NAME      = 3'd2,
    PH_DATA      = 3'd3,
    PH_DONE      = 3'd4
  } phase_e;

  // region tags carried with each item
  localparam logic [2:0] REGION_BUNDLE_HDR = 3'd0;
  localparam logic [2:0] REGION_ENTRY_HDR  = 3'd1;
  localparam logic [2:0] REGION_NAME       = 3'd2;
  localparam logic [2:0] REGION_DATA       = 3'd3;
  localparam logic [2:0] REGION_DISCARD    = 3'd4;

  // configuration register indexes
  localparam int unsigned CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_MAGIC   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_VERSION = 2'd1;

  // result item produced for each input byte
  typedef struct packed {
    logic [7:0]  byte_out;
    logic [2:0]  region;
    logic [31:0] ent_idx;
    logic        field_start;
    logic        end_of_bundle;
    logic        status;
    logic [31:0] hdr_count;
  } result_t;

endpackage

/* design/bcv_in_reg.sv */
// ----------------------------------------------------------------------------
// bcv_in_reg
// input register stage holding one accepted item for the parser
// ----------------------------------------------------------------------------
module bcv_in_reg (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] in_byte_i,
  input  logic       in_last_i,
  input  logic       advance_i,   // downstream takes the held item this cycle
  output logic       valid_o,
  output logic [7:0] byte_o,
  output logic       last_o
);

  logic       valid_q, valid_d;
  logic [7:0] byte_q;
  logic       last_q;

  assign in_ready_o = !valid_q || advance_i;

  always_comb begin
    valid_d = valid_q;
    if (in_ready_o) begin
      valid_d = in_valid_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // payload, no reset needed
  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      byte_q <= in_byte_i;
      last_q <= in_last_i;
    end
  end

  assign valid_o = valid_q;
  assign byte_o  = byte_q;
  assign last_o  = last_q;

endmodule

/* design/bcv_parse.sv */
// ----------------------------------------------------------------------------
// bcv_parse
// bundle walk state and per-byte check and tagging logic
// ----------------------------------------------------------------------------
module bcv_parse
  import bcv_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        step_i,      // consume the current byte
  input  logic [7:0]  byte_i,
  input  logic        last_i,
  input  logic [31:0] magic_i,
  input  logic [31:0] version_i,
  output result_t     result_o
);

  localparam logic [31:0] POS_MAGIC_END   = 32'd3;
  localparam logic [31:0] POS_VERSION_END = 32'd7;
  localparam logic [31:0] POS_COUNT_END   = 32'd11;
  localparam logic [31:0] POS_TOTAL_END   = 32'd15;
  localparam logic [2:0]  BIW_NAME_LEN_END = 3'd3;
  localparam logic [2:0]  BIW_DATA_LEN_END = 3'd7;
  localparam logic [35:0] HDR_BYTES        = 36'd16;

  phase_e      phase_q, phase_d;
  logic [31:0] pos_q, pos_d;
  logic [31:0] word_q, word_d;
  logic [2:0]  biw_q, biw_d;
  logic [31:0] entries_q, entries_d;
  logic [31:0] total_q, total_d;
  logic [31:0] seen_q, seen_d;
  logic [31:0] left_q, left_d;
  logic [31:0] pend_q, pend_d;
  logic        err_q, err_d;

  logic [31:0] shifted;
  logic [31:0] left_dec;
  logic [31:0] seen_inc;
  logic [35:0] min_total;
  logic        err;

  assign shifted   = {word_q[23:0], byte_i};
  assign left_dec  = (left_q != 32'd0) ? left_q - 32'd1 : left_q;
  assign seen_inc  = seen_q + 32'd1;
  assign min_total = {1'b0, entries_q, 3'b000} + HDR_BYTES;

  always_comb begin
    phase_d   = phase_q;
    pos_d     = pos_q;
    word_d    = word_q;
    biw_d     = biw_q;
    entries_d = entries_q;
    total_d   = total_q;
    seen_d    = seen_q;
    left_d    = left_q;
    pend_d    = pend_q;
    err       = err_q;

    result_o               = '0;
    result_o.byte_out      = byte_i;
    result_o.region        = REGION_DISCARD;
    result_o.end_of_bundle = last_i;

    if (err_q) begin
      result_o.region = REGION_DISCARD;
    end else if (phase_q == PH_HEADER) begin
      result_o.region = REGION_BUNDLE_HDR;
      word_d = shifted;
      if (pos_q == POS_MAGIC_END && shifted != magic_i) begin
        err = 1'b1;
      end else if (pos_q == POS_VERSION_END && shifted != version_i) begin
        err = 1'b1;
      end else if (pos_q == POS_COUNT_END) begin
        entries_d = shifted;
        if (shifted == 32'd0) begin
          err = 1'b1;
        end
      end else if (pos_q == POS_TOTAL_END) begin
        total_d = shifted;
        if (min_total > {4'b0000, shifted}) begin
          err = 1'b1;
        end
        phase_d = PH_ENTRY_HDR;
        biw_d   = 3'd0;
      end
      pos_d = pos_q + 32'd1;
    end else begin
      // overrun of the declared total
      if (pos_q >= total_q) begin
        err = 1'b1;
      end
      case (phase_q)
        PH_ENTRY_HDR: begin
          result_o.region  = REGION_ENTRY_HDR;
          result_o.ent_idx = seen_q;
          word_d = shifted;
          if (biw_q == BIW_NAME_LEN_END) begin
            left_d = shifted;
            if (shifted == 32'd0) begin
              err = 1'b1;
            end
            biw_d = biw_q + 3'd1;
          end else if (biw_q == BIW_DATA_LEN_END) begin
            pend_d  = shifted;
            phase_d = PH_NAME;
            biw_d   = 3'd0;
          end else begin
            biw_d = biw_q + 3'd1;
          end
        end
        PH_NAME, PH_DATA: begin
          result_o.region      = (phase_q == PH_NAME) ? REGION_NAME : REGION_DATA;
          result_o.ent_idx     = seen_q;
          result_o.field_start = (biw_q == 3'd0);
          biw_d  = 3'd1;
          left_d = left_dec;
          if (left_dec == 32'd0) begin
            if (phase_q == PH_NAME && pend_q != 32'd0) begin
              phase_d = PH_DATA;
              left_d  = pend_q;
              biw_d   = 3'd0;
            end else begin
              seen_d  = seen_inc;
              phase_d = (seen_inc == entries_q) ? PH_DONE : PH_ENTRY_HDR;
              biw_d   = 3'd0;
            end
          end
        end
        default: begin
          // trailing byte after the last entry
          result_o.region = REGION_DISCARD;
          err = 1'b1;
        end
      endcase
      if (pos_q != '1) begin
        pos_d = pos_q + 32'd1;
      end
    end

    // final byte must close the walk exactly at the declared total
    if (last_i && !err && !(phase_d == PH_DONE && pos_d == total_d)) begin
      err = 1'b1;
    end

    result_o.status    = err;
    result_o.hdr_count = (last_i && !err) ? entries_d : 32'd0;
    err_d = err;

    if (last_i) begin
      phase_d   = PH_HEADER;
      pos_d     = '0;
      word_d    = '0;
      biw_d     = '0;
      entries_d = '0;
      total_d   = '0;
      seen_d    = '0;
      left_d    = '0;
      pend_d    = '0;
      err_d     = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PH_HEADER;
      pos_q     <= '0;
      word_q    <= '0;
      biw_q     <= '0;
      entries_q <= '0;
      total_q   <= '0;
      seen_q    <= '0;
      left_q    <= '0;
      pend_q    <= '0;
      err_q     <= 1'b0;
    end else if (step_i) begin
      phase_q   <= phase_d;
      pos_q     <= pos_d;
      word_q    <= word_d;
      biw_q     <= biw_d;
      entries_q <= entries_d;
      total_q   <= total_d;
      seen_q    <= seen_d;
      left_q    <= left_d;
      pend_q    <= pend_d;
      err_q     <= err_d;
    end
  end

endmodule

/* design/bundle_container_validator.sv */
// each accepted item passes the input register, then the result register
// throughput: one item per cycle, sustained while the output side takes items
// the walk state updates once per byte taken, so byte n+1 follows byte n directly
// reset: rst_ni low clears walk state, both config registers and all valid flags
// after a byte flagged last the walk returns to its reset state, registers kept
// ----------------------------------------------------------------------------
// bundle_container_validator
// checks an encoded bundle byte by byte and tags each byte with its region,
// entry index and running status
// ----------------------------------------------------------------------------
module bundle_container_validator
  import bcv_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // input stream
  input  logic                 s_axis_tvalid_i,
  output logic                 s_axis_tready_o,
  input  logic [7:0]           s_axis_tdata_i,   // [7:0] data_byte
  input  logic                 s_axis_tlast_i,   // last
  // result stream
  output logic                 m_axis_tvalid_o,
  input  logic                 m_axis_tready_i,
  // [7:0] byte_out, [39:8] ent_idx, [40] status, [72:41] hdr_count,
  // [79:73] zero
  output logic [79:0]          m_axis_tdata_o,
  output logic [3:0]           m_axis_tuser_o,   // [2:0] region, [3] field_start
  output logic                 m_axis_tlast_o,   // end_of_bundle
  // configuration writes
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [31:0]          cfg_data_i
);

  // configuration registers; the user must write them only while the block is idle, as the block has no check for it
  logic [31:0] magic_q, version_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      magic_q   <= '0;
      version_q <= '0;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_MAGIC:   magic_q   <= cfg_data_i;
        CFG_VERSION: version_q <= cfg_data_i;
        default: ;  // unknown index, write dropped
      endcase
    end
  end

  // stage 2 state, declared ahead as stage 1 looks at it
  logic    out_valid_q, out_valid_d;
  result_t out_q;

  // stage 1: input register
  logic       s1_valid;
  logic [7:0] s1_byte;
  logic       s1_last;
  logic       s1_advance;   // output register can take a new item

  assign s1_advance = !out_valid_q || m_axis_tready_i;

  bcv_in_reg u_in_reg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_ready_o (s_axis_tready_o),
    .in_byte_i  (s_axis_tdata_i),
    .in_last_i  (s_axis_tlast_i),
    .advance_i  (s1_advance),
    .valid_o    (s1_valid),
    .byte_o     (s1_byte),
    .last_o     (s1_last)
  );

  // walk logic between the input and result registers; state moves on
  // only when the held byte is handed to the result register
  logic    step;
  result_t result;

  assign step = s1_valid && s1_advance;

  bcv_parse u_parse (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .step_i    (step),
    .byte_i    (s1_byte),
    .last_i    (s1_last),
    .magic_i   (magic_q),
    .version_i (version_q),
    .result_o  (result)
  );

  // stage 2: result register, parts the output handshake from the walk
  always_comb begin
    out_valid_d = out_valid_q;
    if (s1_advance) begin
      out_valid_d = s1_valid;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      out_q <= result;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {7'b0000000, out_q.hdr_count, out_q.status,
                            out_q.ent_idx, out_q.byte_out};
  assign m_axis_tuser_o  = {out_q.field_start, out_q.region};
  assign m_axis_tlast_o  = out_q.end_of_bundle;

endmodule
